// File: rtl/hpf_pkg.sv
// Shared types, field widths, codes and reset constants of the handle pool.
package hpf_pkg;

  localparam int POOL_SIZE_DEFAULT = 1024;

  localparam int HANDLE_W = 10;
  localparam int LIMIT_W = 10;
  localparam int INIT_W = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;
  localparam int INIT_RESET = 800;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_HANDLES = 1'b1;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REL_ERROR = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
    logic                evict_valid;
    logic [HANDLE_W-1:0] evict_handle;
  } rsp_t;

  // Commands to the free stack.
  typedef struct packed {
    logic init;
    logic pop;
    logic push;
  } fs_cmd_t;

endpackage

// File: rtl/hpf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hpf_ram #(
  parameter int WIDTH = hpf_pkg::HANDLE_W,
  parameter int DEPTH = hpf_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hpf_free_stack.sv
// Free handle stack: stack memory, fill count and a low-water mark for untouched entries.
module hpf_free_stack #(
  parameter int DEPTH = hpf_pkg::POOL_SIZE_DEFAULT,
  parameter int RESET_COUNT = hpf_pkg::INIT_RESET
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hpf_pkg::fs_cmd_t           cmd,
  input  logic [$clog2(DEPTH+1)-1:0] init_count,
  input  logic [$clog2(DEPTH)-1:0]   push_value,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH)-1:0]   top
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Entries below the low-water mark have not been touched since the last
  // reinit and still hold their own index.
  logic [CNT_W-1:0] low;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] top_idx;
  logic             fresh_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] rdata;
  logic             do_push;

  assign count_m1 = count - 1'b1;
  assign top_idx = count_m1[IDX_W-1:0];
  assign do_push = cmd.push && (count < CNT_W'(DEPTH));

  hpf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(count[IDX_W-1:0]),
    .wdata(push_value),
    .raddr(top_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    fresh_q <= (count <= low);
    idx_q <= top_idx;
  end

  assign top = fresh_q ? idx_q : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(RESET_COUNT);
      low <= CNT_W'(RESET_COUNT);
    end else if (cmd.init) begin
      count <= init_count;
      low <= init_count;
    end else if (cmd.pop) begin
      count <= count_m1;
      if (count_m1 < low) begin
        low <= count_m1;
      end
    end else if (do_push) begin
      count <= count + 1'b1;
    end
  end

endmodule

// File: rtl/handle_pool_with_fifo_eviction.sv
// Top level of the handle pool: request sequencer, in-use ring and result register.
//
// The block hands out handles and takes them back. A request on the req channel
// (req_valid, req_stall, req) either allocates (kind alloc) or releases
// req.handle. Every request yields exactly one result on the rsp channel
// (rsp_valid, rsp_stall, rsp), in request order.
// An allocate is answered from S_ALLOC. A release walks the in-use order from the
// oldest entry in S_SCAN until it finds the handle; for any handle but the oldest,
// S_PREP and S_ROT then copy the entries ahead of it to the back before S_DONE.
// A release that finds nothing, or that arrives with nothing in use, goes to S_DONE
// with an error status.
// This walk follows from the single read port of the in-use ring memory,
// which is walked one entry a cycle for the search and again for the rotation.
// One request is worked on at a time; the next is taken once the previous
// result sits in the output register, even while the receiver still stalls it.
// A stalled result holds the block at the end of the following request.
// Configuration: cfg_we with cfg_index and cfg_data writes pool_limit or
// initial_handles; the latter reinitializes the pool. Write only while idle.
// Reset (rst, synchronous) restores both registers and an empty in-use order;
// no memory clearing pass is needed.
module handle_pool_with_fifo_eviction #(
  parameter int POOL_SIZE = hpf_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  hpf_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output hpf_pkg::rsp_t                      rsp,
  input  logic                               cfg_we,
  input  logic [hpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int EXT_W = (IDX_W > hpf_pkg::HANDLE_W) ? IDX_W : hpf_pkg::HANDLE_W;
  localparam int LIM_W = (CNT_W > hpf_pkg::LIMIT_W) ? CNT_W : hpf_pkg::LIMIT_W;
  localparam int CLP_W = (CNT_W > hpf_pkg::INIT_W) ? CNT_W : hpf_pkg::INIT_W;
  localparam int RESET_N = (hpf_pkg::INIT_RESET > POOL_SIZE) ? POOL_SIZE
                                                            : hpf_pkg::INIT_RESET;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_ROT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(POOL_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [2:0]                    state;
  logic [hpf_pkg::LIMIT_W-1:0]   pool_limit;
  logic [CNT_W-1:0]              created_count;
  logic [CNT_W-1:0]              used_count;
  logic [IDX_W-1:0]              head;
  logic [IDX_W-1:0]              tail;

  // Per-request working registers.
  logic [IDX_W-1:0]              cur_ptr;
  logic [CNT_W-1:0]              k;
  logic [IDX_W-1:0]              match_ptr;
  logic [hpf_pkg::HANDLE_W-1:0]  hreg;
  logic [hpf_pkg::STATUS_W-1:0]  res_status;
  logic                          rel_ok;

  logic                          slot_free;
  logic                          rsp_load;
  logic                          req_fire;
  logic                          cfg_init;
  logic [CLP_W-1:0]              cfg_ext;
  logic [CNT_W-1:0]              init_n;

  logic                          ring_full;
  logic                          from_stack;
  logic                          cap_hit;
  logic                          alloc_ok;
  logic                          alloc_commit;
  logic [IDX_W-1:0]              grant_val;
  logic [EXT_W-1:0]              grant_ext;
  logic [EXT_W-1:0]              evict_ext;
  logic [EXT_W-1:0]              hreg_ext;
  logic                          match;

  logic                          ring_we;
  logic [IDX_W-1:0]              ring_wdata;
  logic [IDX_W-1:0]              ring_raddr;
  logic [IDX_W-1:0]              ring_rdata;

  hpf_pkg::fs_cmd_t              fs_cmd;
  logic [CNT_W-1:0]              fs_count;
  logic [IDX_W-1:0]              fs_top;

  hpf_pkg::rsp_t                 alloc_rsp;
  hpf_pkg::rsp_t                 done_rsp;

  assign slot_free = !rsp_valid || !rsp_stall;
  // A finishing state loads the output register as soon as it is free.
  assign rsp_load = ((state == S_ALLOC) || (state == S_DONE)) && slot_free;
  assign req_stall = (state != S_IDLE);
  assign req_fire = req_valid && !req_stall;

  // Writing initial_handles clamps the preload to the pool size.
  assign cfg_init = cfg_we && (cfg_index == hpf_pkg::CFG_INITIAL_HANDLES);
  assign cfg_ext = CLP_W'(cfg_data);
  assign init_n = (cfg_ext > CLP_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : cfg_ext[CNT_W-1:0];

  // Allocation decision: pop the free stack first, then create a new handle
  // while the created count is within the limit and the pool size.
  assign ring_full = (used_count >= CNT_W'(POOL_SIZE));
  assign from_stack = (fs_count != '0);
  assign cap_hit = (LIM_W'(created_count) > LIM_W'(pool_limit)) ||
                   (created_count >= CNT_W'(POOL_SIZE));
  assign alloc_ok = !ring_full && (from_stack || !cap_hit);
  assign alloc_commit = (state == S_ALLOC) && slot_free && alloc_ok;
  assign grant_val = from_stack ? fs_top : created_count[IDX_W-1:0];
  assign grant_ext = EXT_W'(grant_val);
  assign evict_ext = EXT_W'(ring_rdata);
  assign hreg_ext = EXT_W'(hreg);
  assign match = (evict_ext == hreg_ext);

  always_comb begin
    alloc_rsp = '0;
    if (alloc_ok) begin
      alloc_rsp.status = hpf_pkg::ST_GRANTED;
      alloc_rsp.granted_handle = grant_ext[hpf_pkg::HANDLE_W-1:0];
    end else begin
      alloc_rsp.status = hpf_pkg::ST_EXHAUSTED;
      if (used_count != '0) begin
        alloc_rsp.evict_valid = 1'b1;
        alloc_rsp.evict_handle = evict_ext[hpf_pkg::HANDLE_W-1:0];
      end
    end
    done_rsp = '0;
    done_rsp.status = res_status;
  end

  // The ring read port follows the walk during search and rotation, and
  // otherwise keeps the oldest entry ready for an eviction hint.
  assign ring_raddr = ((state == S_SCAN) || (state == S_ROT)) ? nxt(cur_ptr) : head;
  assign ring_we = alloc_commit || (state == S_ROT);
  assign ring_wdata = (state == S_ROT) ? ring_rdata : grant_val;

  hpf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(POOL_SIZE)
  ) u_ring_ram (
    .clk  (clk),
    .we   (ring_we),
    .waddr(tail),
    .wdata(ring_wdata),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  assign fs_cmd.init = cfg_init;
  assign fs_cmd.pop = alloc_commit && from_stack;
  assign fs_cmd.push = (state == S_DONE) && slot_free && rel_ok;

  hpf_free_stack #(
    .DEPTH(POOL_SIZE),
    .RESET_COUNT(RESET_N)
  ) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fs_cmd),
    .init_count(init_n),
    .push_value(hreg_ext[IDX_W-1:0]),
    .count     (fs_count),
    .top       (fs_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pool_limit <= hpf_pkg::LIMIT_RESET;
      created_count <= CNT_W'(RESET_N);
      used_count <= '0;
      head <= '0;
      tail <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          hpf_pkg::CFG_POOL_LIMIT: begin
            pool_limit <= cfg_data[hpf_pkg::LIMIT_W-1:0];
          end
          hpf_pkg::CFG_INITIAL_HANDLES: begin
            created_count <= init_n;
            used_count <= '0;
            head <= '0;
            tail <= '0;
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            hreg <= req.handle;
            cur_ptr <= head;
            k <= '0;
            if (req.kind == hpf_pkg::KIND_ALLOC) begin
              state <= S_ALLOC;
            end else if (used_count == '0) begin
              // Nothing in use: the release is flagged and ignored.
              res_status <= hpf_pkg::ST_REL_ERROR;
              rel_ok <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_ALLOC: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            rsp <= alloc_rsp;
            if (alloc_ok) begin
              tail <= nxt(tail);
              used_count <= used_count + 1'b1;
              if (!from_stack) begin
                created_count <= created_count + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // ring_rdata holds the entry at offset k from the head.
          if (match) begin
            match_ptr <= cur_ptr;
            rel_ok <= 1'b1;
            res_status <= hpf_pkg::ST_RELEASED;
            state <= (k == '0) ? S_DONE : S_PREP;
          end else if (CNT_W'(k + 1'b1) == used_count) begin
            rel_ok <= 1'b0;
            res_status <= hpf_pkg::ST_REL_ERROR;
            state <= S_DONE;
          end else begin
            cur_ptr <= nxt(cur_ptr);
            k <= k + 1'b1;
          end
        end
        S_PREP: begin
          // Restart the read stream at the head for the rotation.
          cur_ptr <= head;
          state <= S_ROT;
        end
        S_ROT: begin
          // Copy the k entries ahead of the released handle to the back.
          tail <= nxt(tail);
          cur_ptr <= nxt(cur_ptr);
          k <= k - 1'b1;
          if (k == CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            rsp <= done_rsp;
            if (rel_ok) begin
              head <= nxt(match_ptr);
              used_count <= used_count - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Expected tail position: head plus in-use count, wrapped at the pool size.
  logic [CNT_W:0] head_plus_used;
  logic [CNT_W:0] tail_expected;

  assign head_plus_used = (CNT_W + 1)'(head) + (CNT_W + 1)'(used_count);
  assign tail_expected = (head_plus_used >= (CNT_W + 1)'(POOL_SIZE)) ?
                         head_plus_used - (CNT_W + 1)'(POOL_SIZE) : head_plus_used;

  a_grant_counts: assert property (@(posedge clk) disable iff (rst)
    alloc_commit |=> (used_count == $past(used_count) + 1'b1))
    else $error("in-use count did not advance on a grant");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past((state == S_ALLOC) || (state == S_DONE)))
    else $error("result loaded outside a finishing state");

  a_tail_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (tail == tail_expected[IDX_W-1:0]))
    else $error("ring tail out of step with head and in-use count");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((used_count != '0) && (k < used_count)))
    else $error("search walked past the in-use entries");

endmodule

// File: bench/hpf_tb_pkg.sv
// Scoreboard class of the handle pool bench: predicted pool state and result checking.
package hpf_tb_pkg;

  localparam int POOL = hpf_pkg::POOL_SIZE_DEFAULT;

  class pool_scoreboard;
    logic [hpf_pkg::LIMIT_W-1:0]  limit_reg;
    logic [hpf_pkg::INIT_W-1:0]   preload_reg;
    logic [hpf_pkg::HANDLE_W-1:0] free_stack [POOL];
    int                           free_count;
    int                           created_count;
    // Handles in use, oldest first.
    logic [hpf_pkg::HANDLE_W-1:0] in_use [$];
    hpf_pkg::rsp_t                expected_results [$];
    int                           errors;

    function new();
      limit_reg = hpf_pkg::LIMIT_RESET;
      preload_reg = hpf_pkg::INIT_W'(hpf_pkg::INIT_RESET);
      errors = 0;
      refill_pool();
    endfunction

    function void refill_pool();
      for (int i = 0; i < POOL; i++) free_stack[i] = hpf_pkg::HANDLE_W'(i);
      free_count = (preload_reg > POOL) ? POOL : int'(preload_reg);
      created_count = free_count;
      in_use.delete();
    endfunction

    function void set_register(logic [hpf_pkg::CFG_INDEX_W-1:0] index,
                               logic [hpf_pkg::CFG_DATA_W-1:0] data);
      if (index == hpf_pkg::CFG_POOL_LIMIT) begin
        limit_reg = data[hpf_pkg::LIMIT_W-1:0];
      end else if (index == hpf_pkg::CFG_INITIAL_HANDLES) begin
        preload_reg = data[hpf_pkg::INIT_W-1:0];
        refill_pool();
      end
    endfunction

    // Updates the pool for one accepted request and queues the result it must produce.
    function void note_request(hpf_pkg::req_t r);
      hpf_pkg::rsp_t res;
      int pos;
      bit ok;
      logic [hpf_pkg::HANDLE_W-1:0] g;
      logic [hpf_pkg::HANDLE_W-1:0] moved;
      res = '0;
      g = '0;
      if (r.kind == hpf_pkg::KIND_ALLOC) begin
        ok = 1'b1;
        if (in_use.size() >= POOL) begin
          ok = 1'b0;
        end else if (free_count > 0) begin
          free_count--;
          g = free_stack[free_count];
        end else if (created_count > int'(limit_reg) || created_count >= POOL) begin
          ok = 1'b0;
        end else begin
          g = hpf_pkg::HANDLE_W'(created_count);
          created_count++;
        end
        if (ok) begin
          in_use = {in_use, g};
          res.status = hpf_pkg::ST_GRANTED;
          res.granted_handle = g;
        end else begin
          res.status = hpf_pkg::ST_EXHAUSTED;
          if (in_use.size() > 0) begin
            res.evict_valid = 1'b1;
            res.evict_handle = in_use[0];
          end
        end
      end else begin
        pos = -1;
        foreach (in_use[i]) if (pos < 0 && in_use[i] == r.handle) pos = i;
        if (pos < 0) begin
          res.status = hpf_pkg::ST_REL_ERROR;
        end else begin
          if (free_count < POOL) begin
            free_stack[free_count] = r.handle;
            free_count++;
          end
          // The entries ahead of the handle move to the back, then it leaves the front.
          for (int j = 0; j < pos; j++) begin
            moved = in_use.pop_front();
            in_use = {in_use, moved};
          end
          void'(in_use.pop_front());
          res.status = hpf_pkg::ST_RELEASED;
        end
      end
      expected_results = {expected_results, res};
    endfunction

    function void check_result(hpf_pkg::rsp_t got);
      hpf_pkg::rsp_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.granted_handle !== want.granted_handle) begin
        $error("granted_handle: expected %0d, got %0d",
               want.granted_handle, got.granted_handle);
        errors++;
      end
      if (got.evict_valid !== want.evict_valid) begin
        $error("evict_valid: expected %0d, got %0d", want.evict_valid, got.evict_valid);
        errors++;
      end
      if (got.evict_handle !== want.evict_handle) begin
        $error("evict_handle: expected %0d, got %0d",
               want.evict_handle, got.evict_handle);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
// Top of the handle pool bench: clock, reset, request and result drivers, and the test sequence.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Upper bound on the run length, enforced by the watchdog.
  localparam int LIMIT_CYCLES = 2_000_000;
  // Length of the one long receiver hold, and the result count at which it starts.
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT = 60;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 42;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  hpf_pkg::req_t                   req = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  hpf_pkg::rsp_t                   rsp;
  logic                            cfg_we = 1'b0;
  logic [hpf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hpf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  hpf_tb_pkg::pool_scoreboard sb = new();
  int cycles = 0;
  // Counters of the no-idle stretches, one for each side.
  int send_calm = 0;
  int recv_calm = 0;

  handle_pool_with_fifo_eviction dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every result accepted by the receiver is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** handle_pool_with_fifo_eviction: FAILED **");
      $finish;
    end
  end

  // Draws the idle cycles before the next transfer. Now and then a side enters a
  // stretch in which it does not idle at all, so back-to-back traffic is covered too.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Offers one request and waits until the block takes it. The prediction is
  // updated here, in the same process, so the next choice of handle already
  // sees the effect of this request. The valid stays high when no gap follows.
  task automatic send_request(input logic kind,
                              input logic [hpf_pkg::HANDLE_W-1:0] handle);
    hpf_pkg::req_t r;
    int gap;
    r.kind = kind;
    r.handle = handle;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  // The handle field of an allocate request is ignored, so it carries noise.
  task automatic alloc_request();
    send_request(hpf_pkg::KIND_ALLOC, hpf_pkg::HANDLE_W'($urandom_range(0, 1023)));
  endtask

  task automatic release_request(input logic [hpf_pkg::HANDLE_W-1:0] handle);
    send_request(hpf_pkg::KIND_RELEASE, handle);
  endtask

  // Stops offering requests and waits until every predicted result has come out.
  // Every request yields a result, so a few spare cycles are enough after that.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hpf_pkg::CFG_INDEX_W-1:0] index,
                           input logic [hpf_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(index, data);
    @(posedge clk);
  endtask

  // One random phase: a fresh setting of both registers, then a mix of requests.
  // Most releases name a handle that is in use, so the ring gets walked and
  // rotated; the rest name handles on the free stack or arbitrary values.
  task automatic random_phase(input int count);
    logic [hpf_pkg::LIMIT_W-1:0]    lim;
    logic [hpf_pkg::CFG_DATA_W-1:0] pre;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) lim = '0;
    else if (pick < 3) lim = 10'd1023;
    else lim = hpf_pkg::LIMIT_W'($urandom_range(1, 24));
    pick = $urandom_range(0, 9);
    if (pick < 2) pre = '0;
    else if (pick < 3) pre = hpf_pkg::CFG_DATA_W'($urandom_range(1024, 2047));
    else pre = hpf_pkg::CFG_DATA_W'($urandom_range(1, 12));
    // The top bit of the limit write lies outside the register and must be dropped.
    if ($urandom_range(0, 1)) begin
      write_reg(hpf_pkg::CFG_POOL_LIMIT, {1'($urandom_range(0, 1)), lim});
      write_reg(hpf_pkg::CFG_INITIAL_HANDLES, pre);
    end else begin
      write_reg(hpf_pkg::CFG_INITIAL_HANDLES, pre);
      write_reg(hpf_pkg::CFG_POOL_LIMIT, {1'($urandom_range(0, 1)), lim});
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        alloc_request();
      end else if (pick < 80 && sb.in_use.size() > 0) begin
        release_request(sb.in_use[$urandom_range(0, sb.in_use.size() - 1)]);
      end else if (pick < 88 && sb.free_count > 0) begin
        release_request(sb.free_stack[$urandom_range(0, sb.free_count - 1)]);
      end else begin
        release_request(hpf_pkg::HANDLE_W'($urandom_range(0, 1023)));
      end
    end
    drain();
  endtask

  // Receiver: idles a random number of cycles before each result, and once,
  // after a few dozen results, holds off for a long stretch while the sender
  // keeps offering requests, so the block fills up and stalls its input.
  initial begin : receiver
    int gap;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (taken == HOLD_AT && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset setting: 800 handles preloaded, limit 1023.
    // A release of the second-oldest handle forces a rotation of the ring, a
    // repeated release names a handle no longer in use, and the last two
    // releases arrive with nothing in use at all.
    alloc_request();
    alloc_request();
    release_request(10'd798);
    release_request(10'd798);
    release_request(10'd799);
    release_request(10'd0);
    release_request(10'd1023);
    drain();

    // No preload and limit 0: one handle gets created, the next allocate is
    // refused and names the oldest handle in use for eviction.
    write_reg(hpf_pkg::CFG_INITIAL_HANDLES, 11'd0);
    write_reg(hpf_pkg::CFG_POOL_LIMIT, 11'h400);
    alloc_request();
    alloc_request();
    release_request(10'd0);
    alloc_request();
    release_request(10'd0);
    release_request(10'd0);
    alloc_request();
    alloc_request();
    drain();

    // An oversized preload is clamped to the pool size.
    write_reg(hpf_pkg::CFG_POOL_LIMIT, 11'h3FF);
    write_reg(hpf_pkg::CFG_INITIAL_HANDLES, 11'd2047);
    alloc_request();
    alloc_request();
    release_request(10'd1023);
    alloc_request();
    release_request(10'd1022);
    release_request(10'd1023);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(ITEMS_PER_PHASE);

    // Wait for the last results, then a margin in which a stray result would show.
    req_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("** handle_pool_with_fifo_eviction: PASSED **");
    end else begin
      $display("** handle_pool_with_fifo_eviction: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hpf_pkg.sv
rtl/hpf_ram.sv
rtl/hpf_free_stack.sv
rtl/handle_pool_with_fifo_eviction.sv
bench/hpf_tb_pkg.sv
bench/tb_top.sv
